// ===== rtl/rrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rrs_pkg;

  localparam int unsigned MaxTasks = 64;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned CntW     = 7;

  typedef enum logic [1:0] {
    FuncLoad    = 2'd0,
    FuncStep    = 2'd1,
    FuncRestart = 2'd2,
    FuncNone    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KindAck     = 2'd0,
    KindIdle    = 2'd1,
    KindRun     = 2'd2,
    KindAllDone = 2'd3
  } kind_e;

  typedef enum logic {
    CfgQuantum   = 1'b0,
    CfgTaskCount = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StAck,
    StScan,
    StCheck,
    StPop,
    StLoad,
    StTick,
    StFinish
  } state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  task_index;
    logic [15:0] arrival_tick;
    logic [15:0] burst_ticks;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  task_id;
    logic [31:0] run_start;
    logic [31:0] segment_end;
    logic        task_finished;
    logic [31:0] turnaround;
    logic [31:0] waiting;
    logic [31:0] response;
    logic [31:0] switch_count;
    logic [6:0]  done_count;
  } out_t;

  typedef struct packed {
    logic [15:0] arr;
    logic [15:0] bur;
    logic [15:0] rem;
    logic [31:0] fs;
  } task_word_t;

endpackage

`default_nettype wire

// ===== rtl/round_robin_scheduler_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake               Payload
// in       input      in_valid_i/in_ready_o   in_data_i  (rrs_pkg::in_t)
// out      output     out_valid_o/out_ready_i out_data_o (rrs_pkg::out_t)
// cfg      input      cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// Load, restart and unknown transactions are answered from the acknowledge state,
// as is a step with all tasks done. A scan reads the n active task entries in turn.
// A step that finds no ready task returns an idle result; in a dispatch, every tick
// is followed by a new scan of the task memory. Reset leaves the tables unwritten;
// no clearing pass is needed. A result that waits for out_ready_i holds the block in
// its final state.

module round_robin_scheduler_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire rrs_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output rrs_pkg::out_t      out_data_o,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_idx_i,
  input  wire logic [15:0]   cfg_wdata_i
);
  import rrs_pkg::*;

  state_e state_q, state_d;

  logic [15:0] quantum_q;
  logic [6:0]  tcount_q;
  logic [6:0]  n_act;

  task_word_t tmem [MaxTasks];
  task_word_t tmem_rdata_q, tmem_wdata;
  logic [IdxW-1:0] tmem_raddr, tmem_waddr;
  logic tmem_we;

  logic [IdxW-1:0] fmem [MaxTasks];
  logic [IdxW-1:0] fmem_rdata_q, fmem_wdata, fmem_raddr, fmem_waddr;
  logic fmem_we;

  logic [MaxTasks-1:0] adm_q, adm_d, started_q, started_d, fresh_q, fresh_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [31:0] clock_q, clock_d, switches_q, switches_d;
  logic last_vld_q, last_vld_d;
  logic [IdxW-1:0] last_q, last_d;
  logic [CntW-1:0] done_q, done_d;

  logic [CntW-1:0] scan_cnt_q, scan_cnt_d;
  logic pend_vld_q, pend_vld_d;
  logic [IdxW-1:0] pend_idx_q, pend_idx_d;
  logic phase_q, phase_d;
  logic scan_done;

  logic [IdxW-1:0] id_q, id_d;
  logic [15:0] arr_q, arr_d, bur_q, bur_d, rem_q, rem_d, run_q, run_d, tcnt_q, tcnt_d;
  logic [31:0] fs_q, fs_d, seg_q, seg_d;
  logic [1:0] ack_kind_q, ack_kind_d;

  out_t out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic out_free;
  logic in_acc;

  logic [15:0] rem_eff, q_eff;
  logic [31:0] ta;
  logic [CntW-1:0] done_inc;

  assign n_act       = (tcount_q > 7'(MaxTasks)) ? 7'(MaxTasks) : tcount_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign scan_done   = (scan_cnt_q >= n_act) && !pend_vld_q;
  assign rem_eff     = fresh_q[id_q] ? tmem_rdata_q.bur : tmem_rdata_q.rem;
  assign q_eff       = (quantum_q == 16'd0) ? 16'd1 : quantum_q;
  assign ta          = clock_q - {16'd0, arr_q};
  assign done_inc    = (done_q < 7'd127) ? done_q + 7'd1 : done_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (in_data_i.func == FuncStep && done_q < n_act) state_d = StScan;
          else state_d = StAck;
        end
      end
      StAck:    if (out_free) state_d = StIdle;
      StScan: begin
        if (scan_done) begin
          if (!phase_q) state_d = StCheck;
          else if (rem_q == 16'd0 || tcnt_q == run_q) state_d = StFinish;
          else state_d = StTick;
        end
      end
      StCheck: begin
        if (fill_q != '0) state_d = StPop;
        else if (out_free) state_d = StIdle;
      end
      StPop:    state_d = StLoad;
      StLoad:   state_d = (((q_eff < rem_eff) ? q_eff : rem_eff) == 16'd0) ? StFinish : StTick;
      StTick:   state_d = StScan;
      StFinish: if (out_free) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    adm_d = adm_q; started_d = started_q; fresh_d = fresh_q;
    head_d = head_q; fill_d = fill_q; clock_d = clock_q; switches_d = switches_q;
    last_vld_d = last_vld_q; last_d = last_q; done_d = done_q;
    scan_cnt_d = scan_cnt_q; pend_vld_d = pend_vld_q; pend_idx_d = pend_idx_q;
    phase_d = phase_q; id_d = id_q; arr_d = arr_q; bur_d = bur_q; rem_d = rem_q;
    run_d = run_q; tcnt_d = tcnt_q; fs_d = fs_q; seg_d = seg_q; ack_kind_d = ack_kind_q;
    out_d = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    tmem_we = 1'b0; tmem_waddr = id_q; tmem_wdata = '{arr: arr_q, bur: bur_q, rem: rem_q, fs: fs_q};
    tmem_raddr = id_q;
    fmem_we = 1'b0; fmem_waddr = head_q + fill_q[IdxW-1:0]; fmem_wdata = id_q;
    fmem_raddr = head_q;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          ack_kind_d = KindAck;
          scan_cnt_d = '0; pend_vld_d = 1'b0; phase_d = 1'b0;
          unique case (in_data_i.func)
            FuncLoad: begin
              tmem_we    = 1'b1;
              tmem_waddr = in_data_i.task_index;
              tmem_wdata.arr = in_data_i.arrival_tick;
              tmem_wdata.bur = (in_data_i.burst_ticks == 16'd0) ? 16'd1
                                                                : in_data_i.burst_ticks;
              tmem_wdata.rem = tmem_wdata.bur;
              tmem_wdata.fs  = 32'd0;
              started_d[in_data_i.task_index] = 1'b0;
              fresh_d[in_data_i.task_index]   = 1'b1;
            end
            FuncRestart: begin
              adm_d = '0; started_d = '0; fresh_d = '1;
              head_d = '0; fill_d = '0; clock_d = '0; switches_d = '0;
              last_vld_d = 1'b0; last_d = '0; done_d = '0;
            end
            FuncStep:  ack_kind_d = KindAllDone;
            default:   ack_kind_d = KindAck;
          endcase
        end
      end
      StAck: begin
        if (out_free) begin
          out_d = '0;
          out_d.kind = ack_kind_q;
          out_d.switch_count = switches_q;
          out_d.done_count = done_q;
          out_valid_d = 1'b1;
        end
      end
      StScan: begin
        if (pend_vld_q) begin
          if (!adm_q[pend_idx_q] && {16'd0, tmem_rdata_q.arr} <= clock_q) begin
            adm_d[pend_idx_q] = 1'b1;
            if (fill_q < 7'(MaxTasks)) begin
              fmem_we    = 1'b1;
              fmem_wdata = pend_idx_q;
              fill_d     = fill_q + 7'd1;
            end
          end
        end
        if (scan_cnt_q < n_act) begin
          tmem_raddr = scan_cnt_q[IdxW-1:0];
          pend_vld_d = 1'b1;
          pend_idx_d = scan_cnt_q[IdxW-1:0];
          scan_cnt_d = scan_cnt_q + 7'd1;
        end else begin
          pend_vld_d = 1'b0;
        end
      end
      StCheck: begin
        if (fill_q != '0) begin
          head_d = head_q + 6'd1;
          fill_d = fill_q - 7'd1;
        end else if (out_free) begin
          out_d = '0;
          out_d.kind = KindIdle;
          out_d.run_start = clock_q;
          out_d.segment_end = clock_q + 32'd1;
          out_d.switch_count = switches_q;
          out_d.done_count = done_q;
          out_valid_d = 1'b1;
          clock_d = clock_q + 32'd1;
        end
      end
      StPop: begin
        id_d = fmem_rdata_q;
        tmem_raddr = fmem_rdata_q;
      end
      StLoad: begin
        arr_d = tmem_rdata_q.arr;
        bur_d = tmem_rdata_q.bur;
        rem_d = rem_eff;
        run_d = (q_eff < rem_eff) ? q_eff : rem_eff;
        tcnt_d = '0;
        seg_d = clock_q;
        phase_d = 1'b1;
        if (last_vld_q && last_q != id_q) switches_d = switches_q + 32'd1;
        if (!started_q[id_q]) begin
          fs_d = clock_q;
          started_d[id_q] = 1'b1;
        end else begin
          fs_d = tmem_rdata_q.fs;
        end
      end
      StTick: begin
        rem_d = rem_q - 16'd1;
        clock_d = clock_q + 32'd1;
        tcnt_d = tcnt_q + 16'd1;
        scan_cnt_d = '0;
        pend_vld_d = 1'b0;
      end
      StFinish: begin
        if (out_free) begin
          tmem_we = 1'b1;
          fresh_d[id_q] = 1'b0;
          last_vld_d = 1'b1;
          last_d = id_q;
          out_d = '0;
          out_d.kind = KindRun;
          out_d.task_id = id_q;
          out_d.run_start = seg_q;
          out_d.segment_end = clock_q;
          out_d.response = fs_q - {16'd0, arr_q};
          out_d.switch_count = switches_q;
          out_d.done_count = done_q;
          if (rem_q == 16'd0) begin
            done_d = done_inc;
            out_d.done_count = done_inc;
            out_d.task_finished = 1'b1;
            out_d.turnaround = ta;
            out_d.waiting = ta - {16'd0, bur_q};
          end else if (fill_q < 7'(MaxTasks)) begin
            fmem_we = 1'b1;
            fill_d = fill_q + 7'd1;
          end
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tmem_we) tmem[tmem_waddr] <= tmem_wdata;
    tmem_rdata_q <= tmem[tmem_raddr];
    if (fmem_we) fmem[fmem_waddr] <= fmem_wdata;
    fmem_rdata_q <= fmem[fmem_raddr];
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d; arr_q <= arr_d; bur_q <= bur_d; rem_q <= rem_d; run_q <= run_d;
    tcnt_q <= tcnt_d; fs_q <= fs_d; seg_q <= seg_d; pend_idx_q <= pend_idx_d;
    ack_kind_q <= ack_kind_d; out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      quantum_q <= 16'd4; tcount_q <= 7'd1;
      adm_q <= '0; started_q <= '0; fresh_q <= '1;
      head_q <= '0; fill_q <= '0; clock_q <= '0; switches_q <= '0;
      last_vld_q <= 1'b0; last_q <= '0; done_q <= '0;
      scan_cnt_q <= '0; pend_vld_q <= 1'b0; phase_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgQuantum) quantum_q <= cfg_wdata_i;
        else tcount_q <= cfg_wdata_i[6:0];
      end
      adm_q <= adm_d; started_q <= started_d; fresh_q <= fresh_d;
      head_q <= head_d; fill_q <= fill_d; clock_q <= clock_d; switches_q <= switches_d;
      last_vld_q <= last_vld_d; last_q <= last_d; done_q <= done_d;
      scan_cnt_q <= scan_cnt_d; pend_vld_q <= pend_vld_d; phase_q <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire
